[rtl/core/inode_table_allocator_defines.svh]
// Assertion macros for the inode table allocator.
`ifndef INODE_TABLE_ALLOCATOR_DEFINES_SVH
`define INODE_TABLE_ALLOCATOR_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define ITA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ITA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/core/ita_pkg.sv]
// Shared types and codes of the inode table allocator.
package ita_pkg;
   typedef enum logic [2:0] {
      OP_FORMAT = 3'd0, OP_ALLOC = 3'd1, OP_UNLINK = 3'd2, OP_LINK = 3'd3,
      OP_SETSIZE = 3'd4, OP_LOCK = 3'd5, OP_UNLOCK = 3'd6, OP_QUERY = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      ST_OK = 4'd0, ST_NOFMT = 4'd1, ST_NONE = 4'd2, ST_RANGE = 4'd3, ST_ROOT = 4'd4,
      ST_NOTUSED = 4'd5, ST_LOCKED = 4'd6, ST_UNLOCKED = 4'd7, ST_LIMIT = 4'd8
   } status_type;

   // Entry word: flags {lock,dir,used}, links, size, first block.
   localparam int EntryWidth = 3 + 8 + 32 + 16;

   typedef struct packed {
      logic [15:0] blk;
      logic [31:0] size;
      logic [7:0]  links;
      logic        lock;
      logic        dir;
      logic        used;
   } entry_type;
endpackage

[rtl/core/ita_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module ita_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[rtl/core/inode_table_allocator.sv]
// Top level of the inode table allocator: control sequencer around the entry RAM.
//
//  channel | dir | protocol
//  req     | in  | tvalid/tready, tdata, tuser = opcode
//  rsp     | out | tvalid/tready, tdata
//  csr     | in  | write enable + data, entry_count
//
// One item at a time: entry operations pass through read, check and write, and output,
// plus the allocation scan, which visits entries until a free one or the used bound.
// The read step is set by the registered read of the entry RAM.
// Reset is synchronous; entry RAM contents are not cleared.
// A waiting result holds in the output register; req_tready stays low until taken.
module inode_table_allocator #(
   parameter int NUM_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: entry_index[7:0], make_directory[8], new_size[40:9], block_value[56:41]
   input  logic [63:0] req_tdata,
   // tuser: opcode[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: status[3:0], result_index[11:4], is_directory[12], is_locked[13],
   // links[21:14], size_out[53:22], first_block_out[69:54], free_left[78:70],
   // released[79]
   output logic [79:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data
);
   import ita_pkg::*;
   `include "inode_table_allocator_defines.svh"

   localparam int AW = $clog2(NUM_ENTRIES);
   localparam int CW = AW + 1;
   localparam logic [8:0] Lim = (NUM_ENTRIES > 256) ? 9'd256 : 9'(NUM_ENTRIES);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_READ = 5'b00010, S_EXEC = 5'b00100,
      S_SCAN = 5'b01000, S_OUT = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [8:0]  cnt_ff;
   logic        fmt_ff, fmt_in;
   logic [8:0]  ff_ff, ff_in, ub_ff, ub_in, ft_ff, ft_in;
   op_type      op_ff;
   logic [7:0]  idx_ff;
   logic        dir_ff;
   logic [31:0] size_ff;
   logic [15:0] blk_ff;
   logic [79:0] out_ff, out_in;
   logic        vld_ff, vld_in;
   logic [8:0]  scan_ff, scan_in;

   logic           wr_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   entry_type      wr_data, rd_data;
   logic [EntryWidth-1:0] rd_raw;

   ita_ram #(.Width(EntryWidth), .Depth(NUM_ENTRIES)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_raw));
   assign rd_data = entry_type'(rd_raw);

   logic [8:0] limit;
   always_comb begin
      limit = (cnt_ff == 9'd0) ? 9'd1 : cnt_ff;
      if (limit > Lim) limit = Lim;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = out_ff;

   function automatic logic [79:0] pack(status_type st, logic [7:0] ix, entry_type e,
                                        logic show, logic [8:0] fl, logic rel);
      logic [79:0] r;
      r = '0;
      r[3:0] = st;
      r[11:4] = ix;
      if (show) begin
         r[12] = e.dir; r[13] = e.lock; r[21:14] = e.links;
         r[53:22] = e.size; r[69:54] = e.blk;
      end
      r[78:70] = fl;
      r[79] = rel;
      return r;
   endfunction

   // Sequencer: read entry, check and write back, optional scan, present result.
   always_comb begin
      entry_type e;
      logic [CW-1:0] ff_w;
      state_in = state_ff; fmt_in = fmt_ff; ff_in = ff_ff; ub_in = ub_ff; ft_in = ft_ff;
      out_in = out_ff; vld_in = vld_ff; scan_in = scan_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = '0; e = rd_data;
      ff_w = CW'(ff_ff);
      rd_addr = AW'(idx_ff);
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_READ;
         S_READ: state_in = S_EXEC;
         S_EXEC: begin
            state_in = S_OUT;
            if (op_ff == OP_FORMAT) begin
               e = '{blk: blk_ff, size: 32'd0, links: 8'd1, lock: 1'b0, dir: 1'b1,
                     used: 1'b1};
               wr_en = 1'b1; wr_addr = '0; wr_data = e;
               fmt_in = 1'b1; ff_in = 9'd1; ub_in = 9'd1; ft_in = limit - 9'd1;
               out_in = pack(ST_OK, 8'd0, e, 1'b1, limit - 9'd1, 1'b0);
            end else if (!fmt_ff) begin
               out_in = pack(ST_NOFMT, (op_ff == OP_ALLOC) ? 8'd0 : idx_ff, e, 1'b0,
                             ft_ff, 1'b0);
            end else if (op_ff == OP_ALLOC) begin
               if (ft_ff == 9'd0 || ff_ff >= limit) begin
                  out_in = pack(ST_NONE, 8'd0, e, 1'b0, ft_ff, 1'b0);
               end else begin
                  e = '{blk: blk_ff, size: size_ff, links: 8'd1, lock: 1'b0, dir: dir_ff,
                        used: 1'b1};
                  wr_en = 1'b1; wr_addr = ff_w[AW-1:0]; wr_data = e;
                  ft_in = ft_ff - 9'd1;
                  out_in = pack(ST_OK, ff_ff[7:0], e, 1'b1, ft_ff - 9'd1, 1'b0);
                  if (ff_ff == ub_ff) begin
                     ff_in = ff_ff + 9'd1; ub_in = ub_ff + 9'd1;
                  end else begin
                     scan_in = ff_ff + 9'd1;
                     state_in = S_SCAN;
                     rd_addr = AW'(ff_ff + 9'd1);
                  end
               end
            end else if (9'(idx_ff) >= ub_ff) begin
               out_in = pack(ST_RANGE, idx_ff, e, 1'b0, ft_ff, 1'b0);
            end else if (idx_ff == 8'd0 && (op_ff == OP_UNLINK || op_ff == OP_LINK ||
                                           op_ff == OP_SETSIZE)) begin
               out_in = pack(ST_ROOT, idx_ff, e, 1'b0, ft_ff, 1'b0);
            end else if (!rd_data.used) begin
               out_in = pack(ST_NOTUSED, idx_ff, e, 1'b0, ft_ff, 1'b0);
            end else begin
               case (op_ff)
                  OP_UNLINK: begin
                     if (rd_data.links <= 8'd1) begin
                        e.links = 8'd0; e.used = 1'b0;
                        ft_in = ft_ff + 9'd1;
                        if (9'(idx_ff) < ff_ff) ff_in = 9'(idx_ff);
                        if (9'(idx_ff) + 9'd1 == ub_ff) ub_in = ub_ff - 9'd1;
                        out_in = pack(ST_OK, idx_ff, e, 1'b1, ft_ff + 9'd1, 1'b1);
                     end else begin
                        e.links = rd_data.links - 8'd1;
                        out_in = pack(ST_OK, idx_ff, e, 1'b1, ft_ff, 1'b0);
                     end
                     wr_en = 1'b1;
                  end
                  OP_LINK: begin
                     if (rd_data.links == 8'hFF) begin
                        out_in = pack(ST_LIMIT, idx_ff, e, 1'b0, ft_ff, 1'b0);
                     end else begin
                        e.links = rd_data.links + 8'd1; wr_en = 1'b1;
                        out_in = pack(ST_OK, idx_ff, e, 1'b1, ft_ff, 1'b0);
                     end
                  end
                  OP_SETSIZE: begin
                     e.size = size_ff; wr_en = 1'b1;
                     out_in = pack(ST_OK, idx_ff, e, 1'b1, ft_ff, 1'b0);
                  end
                  OP_LOCK: begin
                     if (rd_data.lock) begin
                        out_in = pack(ST_LOCKED, idx_ff, e, 1'b0, ft_ff, 1'b0);
                     end else begin
                        e.lock = 1'b1; wr_en = 1'b1;
                        out_in = pack(ST_OK, idx_ff, e, 1'b1, ft_ff, 1'b0);
                     end
                  end
                  OP_UNLOCK: begin
                     if (!rd_data.lock) begin
                        out_in = pack(ST_UNLOCKED, idx_ff, e, 1'b0, ft_ff, 1'b0);
                     end else begin
                        e.lock = 1'b0; wr_en = 1'b1;
                        out_in = pack(ST_OK, idx_ff, e, 1'b1, ft_ff, 1'b0);
                     end
                  end
                  default: out_in = pack(ST_OK, idx_ff, e, 1'b1, ft_ff, 1'b0);
               endcase
               wr_addr = AW'(idx_ff); wr_data = e;
            end
            if (state_in == S_OUT) vld_in = 1'b1;
         end
         // rd_data holds the entry at scan_ff; read ahead the next one.
         S_SCAN: begin
            rd_addr = AW'(scan_ff + 9'd1);
            if (scan_ff >= ub_ff || !rd_data.used) begin
               ff_in = (scan_ff < ub_ff) ? scan_ff : ub_ff;
               state_in = S_OUT; vld_in = 1'b1;
            end else begin
               scan_in = scan_ff + 9'd1;
            end
         end
         S_OUT: if (vld_ff && rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= 9'd256; fmt_ff <= 1'b0;
         ff_ff <= '0; ub_ff <= '0; ft_ff <= '0; vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; fmt_ff <= fmt_in; ff_ff <= ff_in; ub_ff <= ub_in;
         ft_ff <= ft_in; vld_ff <= vld_in;
         if (csr_wr_en) cnt_ff <= csr_wr_data;
      end
      out_ff <= out_in; scan_ff <= scan_in;
      if (req_tvalid && req_tready) begin
         op_ff <= op_type'(req_tuser); idx_ff <= req_tdata[7:0]; dir_ff <= req_tdata[8];
         size_ff <= req_tdata[40:9]; blk_ff <= req_tdata[56:41];
      end
   end

   `ITA_ASSERT_IMP(a_free_le_256, clock, reset, 1'b1, ft_ff <= 9'd256, "free count overflow")
   `ITA_ASSERT_IMP(a_ff_le_ub, clock, reset, state_ff == S_IDLE, ff_ff <= ub_ff, "first free past bound")
   `ITA_ASSERT_NXT(a_accept_read, clock, reset, req_tvalid && req_tready, state_ff == S_READ, "accept did not start read")
   `ITA_ASSERT_IMP(a_busy_no_valid, clock, reset, state_ff == S_IDLE, !vld_ff, "result pending while idle")
endmodule

[bench/inode_table_checker.sv]
// Checker for the inode table allocator: predicts each response and compares it.
module inode_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data,
   output int          fail_count,
   output int          pending
);
   import ita_pkg::*;

   // Response layout, lowest field last.
   typedef struct packed {
      logic        released;
      logic [8:0]  free_left;
      logic [15:0] first_block;
      logic [31:0] size;
      logic [7:0]  links;
      logic        locked;
      logic        dir;
      logic [7:0]  index;
      status_type  status;
   } inode_rsp_type;

   inode_rsp_type rsp_queue[$];

   // Shadow table
   logic [8:0]  entry_count_q;
   logic        formatted_q;
   logic [8:0]  first_free_q;
   logic [8:0]  used_bound_q;
   logic [8:0]  free_total_q;
   entry_type   table_q [256];

   function automatic logic [8:0] table_size();
      if (entry_count_q == 0) return 9'd1;
      if (entry_count_q > 256) return 9'd256;
      return entry_count_q;
   endfunction

   function automatic inode_rsp_type make_rsp(status_type st, logic [7:0] idx, logic show,
                                              logic rel);
      inode_rsp_type r;
      r = '0;
      r.status    = st;
      r.index     = idx;
      r.free_left = free_total_q;
      r.released  = rel;
      if (show) begin
         r.dir         = table_q[idx].dir;
         r.locked      = table_q[idx].lock;
         r.links       = table_q[idx].links;
         r.size        = table_q[idx].size;
         r.first_block = table_q[idx].blk;
      end
      return r;
   endfunction

   // Take first_free, then move the pointer to the next free entry
   function automatic logic [7:0] claim_entry(logic dir, logic [31:0] size, logic [15:0] blk);
      logic [8:0] idx;
      logic [8:0] j;
      idx = first_free_q;
      table_q[idx[7:0]] = '{blk: blk, size: size, links: 8'd1, lock: 1'b0, dir: dir,
                            used: 1'b1};
      free_total_q = free_total_q - 9'd1;
      if (first_free_q == used_bound_q) begin
         first_free_q = first_free_q + 9'd1;
         used_bound_q = used_bound_q + 9'd1;
      end else begin
         j = first_free_q + 9'd1;
         while (j < used_bound_q && j < 256 && table_q[j[7:0]].used) j = j + 9'd1;
         first_free_q = (j < used_bound_q) ? j : used_bound_q;
      end
      return idx[7:0];
   endfunction

   function automatic inode_rsp_type predict_inode(op_type op, logic [7:0] idx, logic dir,
                                                   logic [31:0] size, logic [15:0] blk);
      logic rel;
      rel = 1'b0;
      if (op == OP_FORMAT) begin
         formatted_q  = 1'b1;
         first_free_q = '0;
         used_bound_q = '0;
         free_total_q = table_size();
         idx = claim_entry(1'b1, 32'd0, blk);
         return make_rsp(ST_OK, idx, 1'b1, 1'b0);
      end
      if (!formatted_q) return make_rsp(ST_NOFMT, (op == OP_ALLOC) ? 8'd0 : idx, 1'b0, 1'b0);
      if (op == OP_ALLOC) begin
         if (free_total_q == 0 || first_free_q >= table_size())
            return make_rsp(ST_NONE, 8'd0, 1'b0, 1'b0);
         idx = claim_entry(dir, size, blk);
         return make_rsp(ST_OK, idx, 1'b1, 1'b0);
      end
      if ({1'b0, idx} >= used_bound_q) return make_rsp(ST_RANGE, idx, 1'b0, 1'b0);
      if (idx == 0 && (op == OP_UNLINK || op == OP_LINK || op == OP_SETSIZE))
         return make_rsp(ST_ROOT, idx, 1'b0, 1'b0);
      if (!table_q[idx].used) return make_rsp(ST_NOTUSED, idx, 1'b0, 1'b0);
      case (op)
         OP_UNLINK: begin
            if (table_q[idx].links <= 1) begin
               table_q[idx].links = 8'd0;
               table_q[idx].used  = 1'b0;
               free_total_q = free_total_q + 9'd1;
               if (idx < first_free_q) first_free_q = {1'b0, idx};
               if ({1'b0, idx} + 9'd1 == used_bound_q) used_bound_q = used_bound_q - 9'd1;
               rel = 1'b1;
            end else begin
               table_q[idx].links = table_q[idx].links - 8'd1;
            end
         end
         OP_LINK: begin
            if (table_q[idx].links == 8'hFF) return make_rsp(ST_LIMIT, idx, 1'b0, 1'b0);
            table_q[idx].links = table_q[idx].links + 8'd1;
         end
         OP_SETSIZE: table_q[idx].size = size;
         OP_LOCK: begin
            if (table_q[idx].lock) return make_rsp(ST_LOCKED, idx, 1'b0, 1'b0);
            table_q[idx].lock = 1'b1;
         end
         OP_UNLOCK: begin
            if (!table_q[idx].lock) return make_rsp(ST_UNLOCKED, idx, 1'b0, 1'b0);
            table_q[idx].lock = 1'b0;
         end
         default: ;
      endcase
      return make_rsp(ST_OK, idx, 1'b1, rel);
   endfunction

   assign pending = rsp_queue.size();

   // Watch all three ports on the rising edge
   always @(posedge clock) begin
      inode_rsp_type want;
      inode_rsp_type got;
      if (reset) begin
         entry_count_q = 9'd256;
         formatted_q   = 1'b0;
         first_free_q  = '0;
         used_bound_q  = '0;
         free_total_q  = '0;
         rsp_queue.delete();
         fail_count    = 0;
      end else begin
         if (csr_wr_en) entry_count_q = csr_wr_data;
         // response transfer: compare with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = inode_rsp_type'(rsp_tdata);
            if (rsp_queue.size() == 0) begin
               $error("unexpected response %h", rsp_tdata);
               fail_count++;
            end else begin
               want = rsp_queue.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.index !== want.index) begin
                  $error("result_index: expected %0d, got %0d", want.index, got.index);
                  fail_count++;
               end
               if (got.dir !== want.dir) begin
                  $error("is_directory: expected %0d, got %0d", want.dir, got.dir);
                  fail_count++;
               end
               if (got.locked !== want.locked) begin
                  $error("is_locked: expected %0d, got %0d", want.locked, got.locked);
                  fail_count++;
               end
               if (got.links !== want.links) begin
                  $error("links: expected %0d, got %0d", want.links, got.links);
                  fail_count++;
               end
               if (got.size !== want.size) begin
                  $error("size_out: expected %h, got %h", want.size, got.size);
                  fail_count++;
               end
               if (got.first_block !== want.first_block) begin
                  $error("first_block_out: expected %h, got %h", want.first_block,
                         got.first_block);
                  fail_count++;
               end
               if (got.free_left !== want.free_left) begin
                  $error("free_left: expected %0d, got %0d", want.free_left, got.free_left);
                  fail_count++;
               end
               if (got.released !== want.released) begin
                  $error("released: expected %0d, got %0d", want.released, got.released);
                  fail_count++;
               end
            end
         end
         // request transfer: predict its response
         if (req_tvalid && req_tready)
            rsp_queue.push_back(predict_inode(op_type'(req_tuser), req_tdata[7:0],
                                              req_tdata[8], req_tdata[40:9],
                                              req_tdata[56:41]));
      end
   end

endmodule

[bench/tb.sv]
// Testbench top for the inode table allocator: stimulus, watchdog and verdict.
module tb;
   import ita_pkg::*;

   localparam int StallLimit = 5000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic        csr_wr_en;
   logic [8:0]  csr_wr_data;
   int          fail_count;
   int          pending;

   int burst_left;
   int quiet_cycles;
   int table_cnt;

   inode_table_allocator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   inode_table_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver stall pattern: rsp_tready always high, random or mostly low, by a random mode
   initial begin
      int mode;
      int cyc;
      mode = 0;
      cyc = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (cyc % 64 == 0) mode = $urandom_range(0, 2);
         cyc++;
         case (mode)
            0:       rsp_tready = 1'b1;
            1:       rsp_tready = $urandom_range(0, 1);
            default: rsp_tready = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // One request transfer; burst and gap handling on the way in
   task automatic send_req(op_type op, logic [7:0] idx, logic dir, logic [31:0] size,
                           logic [15:0] blk);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tuser  = op;
      req_tdata  = {7'd0, blk, size, dir, idx};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Drain all responses with the request side idle
   task automatic drain();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_count(logic [8:0] value);
      drain();
      csr_wr_data = value;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      table_cnt   = (value == 0) ? 1 : (value > 256 ? 256 : value);
   endtask

   task automatic random_item(bit link_heavy);
      int pick;
      op_type op;
      logic [7:0] idx;
      pick = $urandom_range(0, 99);
      if (link_heavy) begin
         op = (pick < 85) ? OP_LINK : (pick < 95 ? OP_UNLINK : OP_QUERY);
         idx = 8'd1;
      end else begin
         if (pick < 2)       op = OP_FORMAT;
         else if (pick < 32) op = OP_ALLOC;
         else if (pick < 52) op = OP_UNLINK;
         else if (pick < 64) op = OP_LINK;
         else if (pick < 72) op = OP_SETSIZE;
         else if (pick < 82) op = OP_LOCK;
         else if (pick < 92) op = OP_UNLOCK;
         else                op = OP_QUERY;
         idx = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, table_cnt));
      end
      send_req(op, idx, 1'($urandom), $urandom, 16'($urandom));
   endtask

   initial begin
      int counts [8];
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_QUERY;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      burst_left  = 0;
      table_cnt   = 256;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: before format, field extremes, each status except ST_LIMIT
      send_req(OP_QUERY, 8'd3, 1'b0, 32'd0, 16'd0);
      send_req(OP_ALLOC, 8'd9, 1'b1, 32'd5, 16'd5);
      send_req(OP_FORMAT, 8'hFF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
      send_req(OP_ALLOC, 8'd0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
      send_req(OP_ALLOC, 8'hFF, 1'b0, 32'd0, 16'd0);
      send_req(OP_QUERY, 8'hFF, 1'b0, 32'd0, 16'd0);
      send_req(OP_UNLINK, 8'd0, 1'b0, 32'd0, 16'd0);
      send_req(OP_LINK, 8'd0, 1'b0, 32'd0, 16'd0);
      send_req(OP_SETSIZE, 8'd0, 1'b0, 32'd7, 16'd0);
      send_req(OP_LINK, 8'd1, 1'b0, 32'd0, 16'd0);
      send_req(OP_LOCK, 8'd1, 1'b0, 32'd0, 16'd0);
      send_req(OP_UNLINK, 8'd1, 1'b0, 32'd0, 16'd0);
      send_req(OP_UNLINK, 8'd1, 1'b0, 32'd0, 16'd0);
      send_req(OP_UNLINK, 8'd1, 1'b0, 32'd0, 16'd0);
      send_req(OP_LOCK, 8'd2, 1'b0, 32'd0, 16'd0);
      send_req(OP_LOCK, 8'd2, 1'b0, 32'd0, 16'd0);
      send_req(OP_UNLOCK, 8'd2, 1'b0, 32'd0, 16'd0);
      send_req(OP_UNLOCK, 8'd2, 1'b0, 32'd0, 16'd0);
      send_req(OP_SETSIZE, 8'd2, 1'b0, 32'hFFFF_FFFF, 16'd0);
      send_req(OP_QUERY, 8'd2, 1'b0, 32'd0, 16'd0);
      send_req(OP_ALLOC, 8'd0, 1'b0, 32'h1234_5678, 16'hA5A5);
      send_req(OP_ALLOC, 8'd0, 1'b1, 32'd1, 16'd1);
      // single-entry table: format then allocation finds none free
      write_count(9'd1);
      send_req(OP_FORMAT, 8'd0, 1'b0, 32'd0, 16'h0F0F);
      send_req(OP_ALLOC, 8'd0, 1'b0, 32'd0, 16'd0);

      // Random phases over several table sizes; odd phases keep the old table
      counts = '{256, 16, 2, 5, 300, 0, 64, 511};
      for (int ph = 0; ph < 8; ph++) begin
         write_count(9'(counts[ph]));
         if (ph % 2 == 0)
            send_req(OP_FORMAT, 8'd0, 1'b0, 32'd0, 16'($urandom));
         // entry 1 must exist for the link-heavy phase to reach the link limit
         if (counts[ph] == 2)
            send_req(OP_ALLOC, 8'd0, 1'b0, 32'd0, 16'd0);
         for (int n = 0; n < ((counts[ph] == 2) ? 400 : 190); n++) begin
            random_item(counts[ph] == 2);
            // hold off the sender until the block is empty
            if (n == 100) drain();
         end
      end

      drain();
      repeat (20) @(negedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ita_pkg.sv
rtl/core/ita_ram.sv
rtl/core/inode_table_allocator.sv
bench/inode_table_checker.sv
bench/tb.sv
